FILE: rtl/ndc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the nd counter address generator
package ndc_pkg;

  localparam int DIMS_DEFAULT         = 4;
  localparam int MAX_DIM_SIZE_DEFAULT = 4096;

  // dimensions that have a size register and a coordinate field
  localparam int REG_DIMS  = 4;
  localparam int REG_IDX_W = $clog2(REG_DIMS);

  localparam int DIGIT_W   = 13;
  localparam int POS_W     = 12;
  localparam int OFFSET_W  = 48;
  localparam int CNT_REG_W = 3;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  typedef enum logic [1:0] {
    OP_ADVANCE   = 2'd0,
    OP_RESTART   = 2'd1,
    OP_TRANSLATE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_SIZE_0     = 3'd0,
    REG_DIM_SIZE_1     = 3'd1,
    REG_DIM_SIZE_2     = 3'd2,
    REG_DIM_SIZE_3     = 3'd3,
    REG_COUNTER_DIGITS = 3'd4
  } reg_idx_t;

  // classified item handed from the front to the back part
  typedef struct packed {
    op_t                            op;
    logic [REG_DIMS-1:0][POS_W-1:0] pos;
    logic                           oor;
  } item_t;

endpackage

FILE: rtl/ndc_front.sv
`timescale 1ns / 1ps
// input side: takes items, checks translate coordinates, queues them for the engine
module ndc_front #(
  parameter int DIMS = ndc_pkg::DIMS_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  input  logic [ndc_pkg::REG_DIMS*ndc_pkg::POS_W-1:0] s_tdata,
  input  logic [1:0]                                  s_tuser,
  input  logic [DIMS-1:0][ndc_pkg::DIGIT_W-1:0]       sizes,
  output logic                                        q_valid,
  output ndc_pkg::item_t                              q_item,
  input  logic                                        q_pop
);

  localparam int NCHK = (DIMS < ndc_pkg::REG_DIMS) ? DIMS : ndc_pkg::REG_DIMS;

  ndc_pkg::item_t                 queue [ndc_pkg::QDEPTH];
  logic [ndc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ndc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ndc_pkg::QCNT_W-1:0]     count;
  ndc_pkg::item_t                 in_item;
  logic                           push;

  always_comb begin
    in_item.op  = ndc_pkg::op_t'(s_tuser);
    in_item.pos = s_tdata;
    in_item.oor = 1'b0;
    // only dimensions that exist can be out of range
    for (int i = 0; i < NCHK; i++) begin
      if ({1'b0, in_item.pos[i]} >= sizes[i]) begin
        in_item.oor = 1'b1;
      end
    end
  end

  assign s_tready = (count < ndc_pkg::QCNT_W'(ndc_pkg::QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + ndc_pkg::QCNT_W'(push) - ndc_pkg::QCNT_W'(q_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ndc_pkg::QCNT_W'(ndc_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != '0)
    else $error("pop from empty queue");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (count == ndc_pkg::QCNT_W'(ndc_pkg::QDEPTH)) && !q_pop
      |=> count == ndc_pkg::QCNT_W'(ndc_pkg::QDEPTH))
    else $error("full queue changed without pop");

endmodule

FILE: rtl/ndc_engine.sv
`timescale 1ns / 1ps
// back part: counter digits, row-major offset sequencer and result register
module ndc_engine #(
  parameter int DIMS = ndc_pkg::DIMS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [DIMS-1:0][ndc_pkg::DIGIT_W-1:0] sizes,
  input  logic [$clog2(DIMS+1)-1:0]             digits_used,
  input  logic                                  q_valid,
  input  ndc_pkg::item_t                        q_item,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [ndc_pkg::OFFSET_W-1:0]          m_tdata,
  output logic [1:0]                            m_tuser,
  output logic                                  m_tlast
);

  localparam int K_W   = $clog2(DIMS + 1);
  localparam int IDX_W = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int NPOS  = (DIMS < ndc_pkg::REG_DIMS) ? DIMS : ndc_pkg::REG_DIMS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_DONE
  } state_t;

  state_t                                state;
  ndc_pkg::item_t                        item;
  logic [IDX_W-1:0]                      idx;
  logic [DIMS-1:0][ndc_pkg::DIGIT_W-1:0] digits;
  logic [ndc_pkg::OFFSET_W-1:0]          acc;
  logic [ndc_pkg::OFFSET_W-1:0]          stride;
  logic                                  carry;
  logic [ndc_pkg::OFFSET_W-1:0]          res_offset;
  logic                                  res_oor;
  logic                                  res_fin;
  logic                                  res_last;

  logic                                  counted;
  logic [ndc_pkg::DIGIT_W-1:0]           pos_sel;
  logic [ndc_pkg::DIGIT_W-1:0]           digit_sum;
  logic [ndc_pkg::OFFSET_W-1:0]          term;
  logic [ndc_pkg::OFFSET_W-1:0]          acc_next;
  logic [ndc_pkg::OFFSET_W-1:0]          stride_next;
  logic                                  out_free;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    counted   = (K_W'(idx) < digits_used);
    digit_sum = digits[idx] + ndc_pkg::DIGIT_W'(carry);
    pos_sel   = '0;
    if (item.op == ndc_pkg::OP_ADVANCE) begin
      if (counted) begin
        pos_sel = digits[idx];
      end
    end else begin
      // dimensions without a coordinate field translate as zero
      for (int j = 0; j < NPOS; j++) begin
        if (int'(idx) == j) begin
          pos_sel = ndc_pkg::DIGIT_W'(item.pos[j]);
        end
      end
    end
    term        = ndc_pkg::OFFSET_W'(pos_sel * stride);
    acc_next    = acc + term;
    stride_next = ndc_pkg::OFFSET_W'(stride * sizes[idx]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      digits   <= '0;
    end else begin
      // a result taken while the next one is ready is replaced in S_DONE
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            item       <= q_item;
            acc        <= '0;
            stride     <= ndc_pkg::OFFSET_W'(1);
            carry      <= 1'b1;
            idx        <= IDX_W'(DIMS - 1);
            res_offset <= '0;
            res_oor    <= (q_item.op == ndc_pkg::OP_TRANSLATE) && q_item.oor;
            res_fin    <= (q_item.op == ndc_pkg::OP_ADVANCE) && (digits[0] >= sizes[0]);
            res_last   <= 1'b0;
            unique case (q_item.op)
              ndc_pkg::OP_ADVANCE: begin
                if (digits[0] >= sizes[0]) begin
                  // already finished: park counted digits at their sizes
                  for (int j = 0; j < DIMS; j++) begin
                    if (K_W'(j) < digits_used) begin
                      digits[j] <= sizes[j];
                    end
                  end
                  state <= S_DONE;
                end else begin
                  state <= S_STEP;
                end
              end
              ndc_pkg::OP_RESTART: begin
                digits <= '0;
                state  <= S_DONE;
              end
              ndc_pkg::OP_TRANSLATE: begin
                if (q_item.oor) begin
                  state <= S_DONE;
                end else begin
                  state <= S_STEP;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_STEP: begin
          acc    <= acc_next;
          stride <= stride_next;
          if (item.op == ndc_pkg::OP_ADVANCE && counted) begin
            if (idx == '0) begin
              if (digit_sum >= sizes[0]) begin
                for (int j = 0; j < DIMS; j++) begin
                  if (K_W'(j) < digits_used) begin
                    digits[j] <= sizes[j];
                  end
                end
                res_last <= 1'b1;
              end else begin
                digits[0] <= digit_sum;
              end
            end else if (digit_sum >= sizes[idx]) begin
              // wraps, stale digits included
              digits[idx] <= '0;
              carry       <= 1'b1;
            end else begin
              digits[idx] <= digit_sum;
              carry       <= 1'b0;
            end
          end
          if (idx == '0) begin
            res_offset <= acc_next;
            state      <= S_DONE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_offset;
            m_tuser  <= {res_fin, res_oor};
            m_tlast  <= res_last;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[1] && m_tlast))
    else $error("finished and last both set");

  a_oor_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1] && !m_tlast)
    else $error("out of range result carries data");

  a_step_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) && (idx != '0) |=> (state == S_STEP) && (idx == $past(idx) - 1'b1))
    else $error("sequencer skipped a dimension");

endmodule

FILE: rtl/nd_counter_address_generator_core.sv
`timescale 1ns / 1ps
// top level: register file, effective sizes, front queue and counter engine
//
//  channel  | direction | handshake                 | payload
//  s_*      | in        | s_tvalid / s_tready       | s_tdata coordinates, s_tuser op
//  m_*      | out       | m_tvalid / m_tready       | m_tdata offset, m_tuser flags, m_tlast
//  apb      | in        | psel / penable / pready   | paddr, pwdata, prdata
//
//  advance of a running counter and in-range translate pass through S_STEP in the
//  engine, one multiply-accumulate step per dimension; restart, unknown ops,
//  out-of-range translate and advance when finished go from S_IDLE to S_DONE
//  a two-item queue sits between the input check and the engine, so inputs are
//  still taken, until the queue is full, while a result waits in the output register
//  reset clears the counter digits, sets sizes to 1 and the digit count to 4
module nd_counter_address_generator_core #(
  parameter int DIMS         = ndc_pkg::DIMS_DEFAULT,
  parameter int MAX_DIM_SIZE = ndc_pkg::MAX_DIM_SIZE_DEFAULT
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // pos_0, pos_1, pos_2, pos_3
  input  logic [ndc_pkg::REG_DIMS*ndc_pkg::POS_W-1:0] s_tdata,
  // op
  input  logic [1:0]                                  s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // offset
  output logic [ndc_pkg::OFFSET_W-1:0]                m_tdata,
  // range_err, finished
  output logic [1:0]                                  m_tuser,
  output logic                                        m_tlast,
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [ndc_pkg::CFG_ADDR_W-1:0]              paddr,
  input  logic [ndc_pkg::CFG_DATA_W-1:0]              pwdata,
  output logic [ndc_pkg::CFG_DATA_W-1:0]              prdata,
  output logic                                        pready
);

  localparam int K_W = $clog2(DIMS + 1);
  localparam logic [16:0] MAX_SIZE = 17'(MAX_DIM_SIZE);

  logic [ndc_pkg::REG_DIMS-1:0][ndc_pkg::DIGIT_W-1:0] dim_size;
  logic [ndc_pkg::CNT_REG_W-1:0]                      counter_digits;
  logic [DIMS-1:0][ndc_pkg::DIGIT_W-1:0]              sizes;
  logic [K_W-1:0]                                     digits_used;
  logic [3:0]                                         cd_ext;
  logic [ndc_pkg::CFG_IDX_W-1:0]                      cfg_idx;
  logic                                               cfg_wr;
  logic                                               q_valid;
  logic                                               q_pop;
  ndc_pkg::item_t                                     q_item;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ndc_pkg::CFG_IDX_W+1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ndc_pkg::REG_DIMS; i++) begin
        dim_size[i] <= ndc_pkg::DIGIT_W'(1);
      end
      counter_digits <= ndc_pkg::CNT_REG_W'(4);
    end else if (cfg_wr) begin
      if (cfg_idx < ndc_pkg::CFG_IDX_W'(ndc_pkg::REG_DIMS)) begin
        if (int'(cfg_idx) < DIMS) begin
          dim_size[cfg_idx[ndc_pkg::REG_IDX_W-1:0]] <= pwdata[ndc_pkg::DIGIT_W-1:0];
        end
      end else if (cfg_idx == ndc_pkg::REG_COUNTER_DIGITS) begin
        counter_digits <= pwdata[ndc_pkg::CNT_REG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_idx < ndc_pkg::CFG_IDX_W'(ndc_pkg::REG_DIMS)) begin
      prdata = ndc_pkg::CFG_DATA_W'(dim_size[cfg_idx[ndc_pkg::REG_IDX_W-1:0]]);
    end else if (cfg_idx == ndc_pkg::REG_COUNTER_DIGITS) begin
      prdata = ndc_pkg::CFG_DATA_W'(counter_digits);
    end
  end

  // zero size reads as 1, sizes above the maximum are clamped
  always_comb begin
    for (int i = 0; i < DIMS; i++) begin
      sizes[i] = ndc_pkg::DIGIT_W'(1);
      if (i < ndc_pkg::REG_DIMS) begin
        if (dim_size[i] == '0) begin
          sizes[i] = ndc_pkg::DIGIT_W'(1);
        end else if (17'(dim_size[i]) > MAX_SIZE) begin
          sizes[i] = MAX_SIZE[ndc_pkg::DIGIT_W-1:0];
        end else begin
          sizes[i] = dim_size[i];
        end
      end
    end
  end

  always_comb begin
    cd_ext = {1'b0, counter_digits};
    if (cd_ext == '0) begin
      digits_used = K_W'(1);
    end else if (cd_ext > 4'(DIMS)) begin
      digits_used = K_W'(DIMS);
    end else begin
      digits_used = K_W'(cd_ext);
    end
  end

  ndc_front #(
    .DIMS (DIMS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .sizes    (sizes),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ndc_engine #(
    .DIMS (DIMS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .sizes       (sizes),
    .digits_used (digits_used),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule
